FILE: hdl/ttia_pkg.sv
// ----------------------------------------------------------------------------
// ttia_pkg: shared types, constants and helpers for the interrupt arbiter
// Item types for both channels, the access modes, the winner record passed
// from the priority tree, and the level and rank decode functions.
// ----------------------------------------------------------------------------
package ttia_pkg;

	localparam int CONTROL_SLOTS_DEF    = 12;
	localparam int INTERNAL_SOURCES_DEF = 10;
	localparam int PIN_REG_OFFSET_DEF   = 6;
	localparam int MASK_REG_OFFSET_DEF  = 72;
	localparam int CONTROL_BASE_DEF     = 76;

	localparam int PIN_COUNT = 4;

	// Within-level score, larger wins. External pins sit between IP=10 and IP=01.
	localparam logic [2:0] SCORE_IP11 = 3'd4;
	localparam logic [2:0] SCORE_IP10 = 3'd3;
	localparam logic [2:0] SCORE_EXT  = 3'd2;
	localparam logic [2:0] SCORE_IP01 = 3'd1;
	localparam logic [2:0] SCORE_IP00 = 3'd0;

	localparam int AVEC_BIT = 7;

	typedef enum logic [2:0] {
		MODE_REG_WR   = 3'd0,
		MODE_REG_RD   = 3'd1,
		MODE_INT_PEND = 3'd2,
		MODE_EXT_PEND = 3'd3,
		MODE_INT_VEC  = 3'd4,
		MODE_EXT_VEC  = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] offset;
		logic [7:0] data_byte;
		logic [3:0] source_index;
		logic       asserted;
	} req_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] irq_level;
		logic [7:0] irq_vector;
		logic       autovector;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0] level;
		logic [7:0] vector;
		logic       autovector;
	} winner_t;

	function automatic logic [2:0] ip_score(input logic [1:0] ip);
		logic [2:0] s;
		case (ip)
			2'd3:    s = SCORE_IP11;
			2'd2:    s = SCORE_IP10;
			2'd1:    s = SCORE_IP01;
			default: s = SCORE_IP00;
		endcase
		return s;
	endfunction

	// Pins in order irq7, irq5, irq3, irq1; the select register moves three of them.
	function automatic logic [2:0] pin_level(input logic [1:0] pin, input logic [7:0] sel);
		logic [2:0] l;
		case (pin)
			2'd0:    l = 3'd7;
			2'd1:    l = sel[2] ? 3'd4 : 3'd5;
			2'd2:    l = sel[1] ? 3'd6 : 3'd3;
			default: l = sel[0] ? 3'd2 : 3'd1;
		endcase
		return l;
	endfunction

endpackage

FILE: hdl/ttia_regs.sv
// ----------------------------------------------------------------------------
// ttia_regs: register file and source state of the interrupt arbiter
// Applies one accepted item to the registers, pending bits and vectors, and
// returns the read data for register reads.
// ----------------------------------------------------------------------------
module ttia_regs
	import ttia_pkg::*;
#(
	parameter int CONTROL_SLOTS    = CONTROL_SLOTS_DEF,
	parameter int INTERNAL_SOURCES = INTERNAL_SOURCES_DEF,
	parameter int PIN_REG_OFFSET   = PIN_REG_OFFSET_DEF,
	parameter int MASK_REG_OFFSET  = MASK_REG_OFFSET_DEF,
	parameter int CONTROL_BASE     = CONTROL_BASE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  req_item_t       req,
	output logic [7:0]      rd_data,
	output logic [7:0]      pin_sel,
	output logic [7:0]      avec_mask,
	output logic [7:0]      src_ctl  [INTERNAL_SOURCES],
	output logic            int_pend [INTERNAL_SOURCES],
	output logic [7:0]      int_vec  [INTERNAL_SOURCES],
	output logic            ext_pend [PIN_COUNT],
	output logic [7:0]      ext_vec  [PIN_COUNT]
);

	logic [7:0] pin_sel_q;
	logic [7:0] avec_mask_q;
	logic [7:0] ctl_q      [CONTROL_SLOTS];
	logic       int_pend_q [INTERNAL_SOURCES];
	logic [7:0] int_vec_q  [INTERNAL_SOURCES];
	logic       ext_pend_q [PIN_COUNT];
	logic [7:0] ext_vec_q  [PIN_COUNT];

	logic       pin_hit;
	logic       mask_hit;
	logic       ctl_hit;
	logic [8:0] ctl_off;

	// Pin register wins an overlap, then the mask, then the control window.
	assign pin_hit  = req.offset == 8'(PIN_REG_OFFSET);
	assign mask_hit = req.offset == 8'(MASK_REG_OFFSET);
	assign ctl_off  = {1'b0, req.offset} - 9'(CONTROL_BASE);
	assign ctl_hit  = !pin_hit && !mask_hit && ({1'b0, req.offset} >= 9'(CONTROL_BASE))
			&& (ctl_off < 9'(CONTROL_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_sel_q   <= '0;
			avec_mask_q <= '0;
			for (int i = 0; i < CONTROL_SLOTS; i++) ctl_q[i] <= '0;
			for (int i = 0; i < INTERNAL_SOURCES; i++) begin
				int_pend_q[i] <= 1'b0;
				int_vec_q[i]  <= '0;
			end
			for (int i = 0; i < PIN_COUNT; i++) begin
				ext_pend_q[i] <= 1'b0;
				ext_vec_q[i]  <= '0;
			end
		end else if (wr_en) begin
			if (req.mode == MODE_REG_WR) begin
				if (pin_hit) pin_sel_q <= req.data_byte;
				if (!pin_hit && mask_hit) avec_mask_q <= req.data_byte;
				for (int i = 0; i < CONTROL_SLOTS; i++) begin
					if (ctl_hit && ctl_off == 9'(i)) ctl_q[i] <= req.data_byte;
				end
			end
			for (int i = 0; i < INTERNAL_SOURCES; i++) begin
				if (req.source_index == 4'(i)) begin
					if (req.mode == MODE_INT_PEND) int_pend_q[i] <= req.asserted;
					if (req.mode == MODE_INT_VEC) int_vec_q[i] <= req.data_byte;
				end
			end
			for (int i = 0; i < PIN_COUNT; i++) begin
				if (req.source_index == 4'(i)) begin
					if (req.mode == MODE_EXT_PEND) ext_pend_q[i] <= req.asserted;
					if (req.mode == MODE_EXT_VEC) ext_vec_q[i] <= req.data_byte;
				end
			end
		end
	end

	always_comb begin
		rd_data = '0;
		if (req.mode == MODE_REG_RD) begin
			if (pin_hit) rd_data = pin_sel_q;
			else if (mask_hit) rd_data = avec_mask_q;
			else begin
				for (int i = 0; i < CONTROL_SLOTS; i++) begin
					if (ctl_hit && ctl_off == 9'(i)) rd_data = ctl_q[i];
				end
			end
		end
	end

	// Sources past the last control slot see a zero control byte.
	for (genvar g = 0; g < INTERNAL_SOURCES; g++) begin : g_src
		if (g < CONTROL_SLOTS) begin : g_slot
			assign src_ctl[g] = ctl_q[g];
		end else begin : g_none
			assign src_ctl[g] = '0;
		end
		assign int_pend[g] = int_pend_q[g];
		assign int_vec[g]  = int_vec_q[g];
	end

	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_pin
		assign ext_pend[g] = ext_pend_q[g];
		assign ext_vec[g]  = ext_vec_q[g];
	end

	assign pin_sel   = pin_sel_q;
	assign avec_mask = avec_mask_q;

endmodule

FILE: hdl/ttia_pick.sv
// ----------------------------------------------------------------------------
// ttia_pick: priority tree over all interrupt sources
// Scores every internal source and external pin by level and rank, then
// reduces them through a binary tree in which the lower index wins a tie.
// ----------------------------------------------------------------------------
module ttia_pick
	import ttia_pkg::*;
#(
	parameter int INTERNAL_SOURCES = INTERNAL_SOURCES_DEF
) (
	input  logic [7:0] pin_sel,
	input  logic [7:0] avec_mask,
	input  logic [7:0] src_ctl  [INTERNAL_SOURCES],
	input  logic       int_pend [INTERNAL_SOURCES],
	input  logic [7:0] int_vec  [INTERNAL_SOURCES],
	input  logic       ext_pend [PIN_COUNT],
	input  logic [7:0] ext_vec  [PIN_COUNT],
	output winner_t    winner
);

	localparam int CANDS  = INTERNAL_SOURCES + PIN_COUNT;
	localparam int DEPTH  = $clog2(CANDS);
	localparam int LEAVES = 1 << DEPTH;

	// Heap order: node n has children 2n and 2n+1; leaves start at LEAVES.
	logic [5:0] key [1:2*LEAVES-1];
	logic [7:0] vec [1:2*LEAVES-1];
	logic       av  [1:2*LEAVES-1];

	always_comb begin
		logic [2:0] lvl;
		for (int n = 1; n < 2 * LEAVES; n++) begin
			key[n] = '0;
			vec[n] = '0;
			av[n]  = 1'b0;
		end
		for (int i = 0; i < INTERNAL_SOURCES; i++) begin
			lvl = src_ctl[i][4:2];
			if (int_pend[i] && lvl != 3'd0) begin
				key[LEAVES + i] = {lvl, ip_score(src_ctl[i][1:0])};
				vec[LEAVES + i] = int_vec[i];
				av[LEAVES + i]  = src_ctl[i][AVEC_BIT];
			end
		end
		for (int p = 0; p < PIN_COUNT; p++) begin
			lvl = pin_level(2'(p), pin_sel);
			if (ext_pend[p]) begin
				key[LEAVES + INTERNAL_SOURCES + p] = {lvl, SCORE_EXT};
				vec[LEAVES + INTERNAL_SOURCES + p] = ext_vec[p];
				av[LEAVES + INTERNAL_SOURCES + p]  = avec_mask[lvl];
			end
		end
		// The right child only wins when strictly better.
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (key[2 * n + 1] > key[2 * n]) begin
				key[n] = key[2 * n + 1];
				vec[n] = vec[2 * n + 1];
				av[n]  = av[2 * n + 1];
			end else begin
				key[n] = key[2 * n];
				vec[n] = vec[2 * n];
				av[n]  = av[2 * n];
			end
		end
	end

	assign winner.level      = key[1][5:3];
	assign winner.vector     = vec[1];
	assign winner.autovector = av[1];

endmodule

FILE: hdl/two_tier_interrupt_arbiter.sv
// ----------------------------------------------------------------------------
// two_tier_interrupt_arbiter: two-tier priority interrupt arbiter
// Takes register accesses and source events, and answers each with the read
// data and the currently presented interrupt level, vector and autovector.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      input      req_valid/req_ready  req_item_t (mode, offset, data, index, asserted)
//   rsp      output     rsp_valid/rsp_ready  rsp_item_t (read data, level, vector, avec)
//
// One item is accepted per cycle while the pipeline has room. The registers
// and source state are updated at the accepting edge, and the item's read data
// goes into the stage register. When the stage item moves on, the priority
// tree scores the updated state and the response register captures it. The
// response register and the stage in front of it form a two-deep path, so a
// stalled response only blocks input once both are full. Reset clears all
// registers, pending bits and vectors.
//
module two_tier_interrupt_arbiter
	import ttia_pkg::*;
#(
	parameter int CONTROL_SLOTS    = CONTROL_SLOTS_DEF,
	parameter int INTERNAL_SOURCES = INTERNAL_SOURCES_DEF,
	parameter int PIN_REG_OFFSET   = PIN_REG_OFFSET_DEF,
	parameter int MASK_REG_OFFSET  = MASK_REG_OFFSET_DEF,
	parameter int CONTROL_BASE     = CONTROL_BASE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic       accept;
	logic       advance;
	logic [7:0] rd_data;
	logic       valid_s1;
	logic [7:0] rd_s1;
	logic       rsp_valid_q;
	rsp_item_t  rsp_q;

	logic [7:0] pin_sel;
	logic [7:0] avec_mask;
	logic [7:0] src_ctl  [INTERNAL_SOURCES];
	logic       int_pend [INTERNAL_SOURCES];
	logic [7:0] int_vec  [INTERNAL_SOURCES];
	logic       ext_pend [PIN_COUNT];
	logic [7:0] ext_vec  [PIN_COUNT];
	winner_t    winner;

	// The stage item moves on when the response register is free or draining.
	// The state may only change when the stage item is also leaving, since the
	// winner it is waiting for is computed from the live state.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	ttia_regs #(
		.CONTROL_SLOTS   (CONTROL_SLOTS),
		.INTERNAL_SOURCES(INTERNAL_SOURCES),
		.PIN_REG_OFFSET  (PIN_REG_OFFSET),
		.MASK_REG_OFFSET (MASK_REG_OFFSET),
		.CONTROL_BASE    (CONTROL_BASE)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.req      (req),
		.rd_data  (rd_data),
		.pin_sel  (pin_sel),
		.avec_mask(avec_mask),
		.src_ctl  (src_ctl),
		.int_pend (int_pend),
		.int_vec  (int_vec),
		.ext_pend (ext_pend),
		.ext_vec  (ext_vec)
	);

	ttia_pick #(
		.INTERNAL_SOURCES(INTERNAL_SOURCES)
	) u_pick (
		.pin_sel  (pin_sel),
		.avec_mask(avec_mask),
		.src_ctl  (src_ctl),
		.int_pend (int_pend),
		.int_vec  (int_vec),
		.ext_pend (ext_pend),
		.ext_vec  (ext_vec),
		.winner   (winner)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// Read data is taken before the update; a read never writes anything.
	always_ff @(posedge clk) begin
		if (accept) rd_s1 <= rd_data;
		if (advance) begin
			rsp_q.read_data  <= rd_s1;
			rsp_q.irq_level  <= winner.level;
			rsp_q.irq_vector <= winner.vector;
			rsp_q.autovector <= winner.autovector;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach the stage register");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("stage item did not reach the response register");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && rsp_valid_q && !rsp_ready))
		else $error("input stalled while the pipeline had room");

	a_idle_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.irq_level == 3'd0) |-> (rsp.irq_vector == 8'd0 && !rsp.autovector))
		else $error("vector or autovector presented without a level");

endmodule

FILE: dv/two_tier_interrupt_arbiter_checker.sv
// ----------------------------------------------------------------------------
// two_tier_interrupt_arbiter_checker: response checker for the arbiter
// Keeps its own copy of the registers and source state, works out the read
// data and the presented winner for every accepted request item, and compares
// each accepted response item field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module two_tier_interrupt_arbiter_checker
	import ttia_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_item_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp,
	output int        fail_count,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CTRL_SLOTS = CONTROL_SLOTS_DEF;
	localparam int N_INT      = INTERNAL_SOURCES_DEF;

	// Within-level order, smaller is stronger. Pins rank between IP=10 and IP=01.
	localparam int RANK_IP11 = 0;
	localparam int RANK_IP10 = 1;
	localparam int RANK_PIN  = 2;
	localparam int RANK_IP01 = 3;
	localparam int RANK_IP00 = 4;
	localparam int RANK_NONE = 5;

	logic [7:0] pin_sel;
	logic [7:0] avec_mask;
	logic [7:0] ctrl [CTRL_SLOTS];
	logic       int_pend [N_INT];
	logic       ext_pend [PIN_COUNT];
	logic [7:0] int_vec [N_INT];
	logic [7:0] ext_vec [PIN_COUNT];

	rsp_item_t answer_fifo[$];
	rsp_item_t fresh;
	rsp_item_t oldest;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	// Applies one access to the local state, then scores every contender.
	task automatic arbitrate(input req_item_t it, output rsp_item_t ans);
		int slot;
		int best_level;
		int best_rank;
		int level;
		int rank;
		logic [7:0] cb;
		ans = '0;
		slot = int'(it.offset) - CONTROL_BASE_DEF;
		case (it.mode)
			MODE_REG_WR: begin
				if (it.offset == PIN_REG_OFFSET_DEF) pin_sel = it.data_byte;
				else if (it.offset == MASK_REG_OFFSET_DEF) avec_mask = it.data_byte;
				else if (slot >= 0 && slot < CTRL_SLOTS) ctrl[slot] = it.data_byte;
			end
			MODE_REG_RD: begin
				if (it.offset == PIN_REG_OFFSET_DEF) ans.read_data = pin_sel;
				else if (it.offset == MASK_REG_OFFSET_DEF) ans.read_data = avec_mask;
				else if (slot >= 0 && slot < CTRL_SLOTS) ans.read_data = ctrl[slot];
			end
			MODE_INT_PEND: if (it.source_index < N_INT) int_pend[it.source_index] = it.asserted;
			MODE_EXT_PEND: if (it.source_index < PIN_COUNT) ext_pend[it.source_index] = it.asserted;
			MODE_INT_VEC:  if (it.source_index < N_INT) int_vec[it.source_index] = it.data_byte;
			MODE_EXT_VEC:  if (it.source_index < PIN_COUNT) ext_vec[it.source_index] = it.data_byte;
			default: ;
		endcase

		best_level = 0;
		best_rank  = RANK_NONE;
		for (int i = 0; i < N_INT; i++) begin
			cb = (i < CTRL_SLOTS) ? ctrl[i] : 8'h00;
			level = int'(cb[4:2]);
			case (cb[1:0])
				2'b11:   rank = RANK_IP11;
				2'b10:   rank = RANK_IP10;
				2'b01:   rank = RANK_IP01;
				default: rank = RANK_IP00;
			endcase
			if (int_pend[i] && level != 0 &&
					(level > best_level || (level == best_level && rank < best_rank))) begin
				best_level = level;
				best_rank = rank;
				ans.irq_level = level[2:0];
				ans.irq_vector = int_vec[i];
				ans.autovector = cb[7];
			end
		end
		for (int p = 0; p < PIN_COUNT; p++) begin
			case (p)
				0:       level = 7;
				1:       level = pin_sel[2] ? 4 : 5;
				2:       level = pin_sel[1] ? 6 : 3;
				default: level = pin_sel[0] ? 2 : 1;
			endcase
			if (ext_pend[p] &&
					(level > best_level || (level == best_level && RANK_PIN < best_rank))) begin
				best_level = level;
				best_rank = RANK_PIN;
				ans.irq_level = level[2:0];
				ans.irq_vector = ext_vec[p];
				ans.autovector = avec_mask[level];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_sel = 8'h00;
			avec_mask = 8'h00;
			for (int i = 0; i < CTRL_SLOTS; i++) ctrl[i] = 8'h00;
			for (int i = 0; i < N_INT; i++) begin
				int_pend[i] = 1'b0;
				int_vec[i] = 8'h00;
			end
			for (int p = 0; p < PIN_COUNT; p++) begin
				ext_pend[p] = 1'b0;
				ext_vec[p] = 8'h00;
			end
			answer_fifo.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready) begin
				arbitrate(req, fresh);
				answer_fifo.push_back(fresh);
			end
			if (rsp_valid && rsp_ready) begin
				if (answer_fifo.size() == 0) begin
					report_mismatch("response item with none outstanding", rsp.irq_vector, 8'h00);
				end else begin
					oldest = answer_fifo.pop_front();
					if (rsp.read_data !== oldest.read_data)
						report_mismatch("read_data", rsp.read_data, oldest.read_data);
					if (rsp.irq_level !== oldest.irq_level)
						report_mismatch("irq_level", 8'(rsp.irq_level), 8'(oldest.irq_level));
					if (rsp.irq_vector !== oldest.irq_vector)
						report_mismatch("irq_vector", rsp.irq_vector, oldest.irq_vector);
					if (rsp.autovector !== oldest.autovector)
						report_mismatch("autovector", 8'(rsp.autovector),
								8'(oldest.autovector));
				end
			end
			outstanding <= answer_fifo.size();
		end
	end

endmodule

FILE: dv/two_tier_interrupt_arbiter_tb.sv
// ----------------------------------------------------------------------------
// two_tier_interrupt_arbiter_tb: top-level testbench for the interrupt arbiter
// Drives a directed set of register accesses and source events, then random
// traffic in four phases of sender idling and receiver stalls. The checker
// beside the block predicts and compares every response item.
// ----------------------------------------------------------------------------
module two_tier_interrupt_arbiter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ttia_pkg::*;

	// Modes 6 and 7 have no function; the block must leave its state alone.
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	localparam logic [7:0] OFS_PIN      = 8'(PIN_REG_OFFSET_DEF);
	localparam logic [7:0] OFS_MASK     = 8'(MASK_REG_OFFSET_DEF);
	localparam logic [7:0] OFS_CTRL     = 8'(CONTROL_BASE_DEF);
	localparam logic [7:0] OFS_NONE_LOW = 8'h00;
	localparam logic [7:0] OFS_NONE_TOP = 8'hFF;

	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES          = 4;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	int fail_count;
	int outstanding;

	// Percent of cycles in which the sender holds back, and the receiver stalls.
	int idle_pct  = 0;
	int stall_pct = 0;

	// Idling mix for each random phase: none, sender only, receiver only, both.
	int phase_idle  [PHASES] = '{0, 85, 0, 28};
	int phase_stall [PHASES] = '{0, 0, 85, 28};

	two_tier_interrupt_arbiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	two_tier_interrupt_arbiter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver decides once per cycle, at the falling edge, whether it stalls.
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Builds one request item from its fields.
	function automatic req_item_t access(input logic [2:0] mode, input logic [7:0] offset,
			input logic [7:0] data, input logic [3:0] index, input logic asserted);
		req_item_t it;
		it.mode = mode;
		it.offset = offset;
		it.data_byte = data;
		it.source_index = index;
		it.asserted = asserted;
		return it;
	endfunction

	// Register offsets for random accesses: mostly modeled registers, sometimes
	// any byte at all so that unmodeled offsets and every offset bit get exercised.
	function automatic logic [7:0] pick_offset();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'($urandom);
		if (r == 1) return OFS_PIN;
		if (r == 2) return OFS_MASK;
		return OFS_CTRL + 8'($urandom_range(0, CONTROL_SLOTS_DEF - 1));
	endfunction

	// One random request item. Every field is filled with random bits first, so
	// unused fields still toggle, then the mode and the fields that matter are
	// steered toward accesses that reach the arbitration logic. A small share is
	// pure noise, including the two unused modes and out-of-range indexes.
	function automatic req_item_t random_access();
		req_item_t it;
		int pick;
		it.mode = 3'($urandom);
		it.offset = 8'($urandom);
		it.data_byte = 8'($urandom);
		it.source_index = 4'($urandom);
		it.asserted = ($urandom_range(0, 99) < 60);
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			it.mode = MODE_REG_WR;
			it.offset = pick_offset();
		end else if (pick < 38) begin
			it.mode = MODE_REG_RD;
			it.offset = pick_offset();
		end else if (pick < 62) begin
			it.mode = MODE_INT_PEND;
			if ($urandom_range(0, 99) < 85)
				it.source_index = 4'($urandom_range(0, INTERNAL_SOURCES_DEF - 1));
		end else if (pick < 76) begin
			it.mode = MODE_EXT_PEND;
			if ($urandom_range(0, 99) < 85)
				it.source_index = 4'($urandom_range(0, PIN_COUNT - 1));
		end else if (pick < 86) begin
			it.mode = MODE_INT_VEC;
			if ($urandom_range(0, 99) < 85)
				it.source_index = 4'($urandom_range(0, INTERNAL_SOURCES_DEF - 1));
		end else if (pick < 94) begin
			it.mode = MODE_EXT_VEC;
			if ($urandom_range(0, 99) < 85)
				it.source_index = 4'($urandom_range(0, PIN_COUNT - 1));
		end
		return it;
	endfunction

	// Offers one item. Idle cycles are decided at each falling edge, and valid
	// gets a single assignment per edge so that a valid that stays high from one
	// item to the next is never dropped and raised in the same step. The task
	// returns at the rising edge where the item is taken.
	task automatic send_item(input req_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// Stops offering and waits until every predicted response item has arrived.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling on either side.
		// All registers read as zero straight out of reset.
		send_item(access(MODE_REG_RD, OFS_PIN, 8'h00, 4'd0, 1'b0));
		send_item(access(MODE_REG_RD, OFS_MASK, 8'h00, 4'd0, 1'b0));
		send_item(access(MODE_REG_RD, OFS_CTRL + 8'd11, 8'h00, 4'd0, 1'b0));
		// Source 0 at level 7, IP=11, autovectored; it wins alone.
		send_item(access(MODE_REG_WR, OFS_CTRL, 8'hFF, 4'd0, 1'b0));
		send_item(access(MODE_INT_PEND, 8'h00, 8'h00, 4'd0, 1'b1));
		send_item(access(MODE_INT_VEC, 8'h00, 8'hA5, 4'd0, 1'b0));
		// The irq7 pin at the same level loses to IP=11.
		send_item(access(MODE_EXT_PEND, 8'h00, 8'h00, 4'd0, 1'b1));
		send_item(access(MODE_EXT_VEC, 8'h00, 8'h5A, 4'd0, 1'b0));
		send_item(access(MODE_REG_WR, OFS_MASK, 8'h80, 4'd0, 1'b0));
		// Dropping source 0 to IP=01 lets the pin take over, autovectored by the mask.
		send_item(access(MODE_REG_WR, OFS_CTRL, 8'h1D, 4'd0, 1'b0));
		// Source 9 at level 7, IP=11 beats both; top vector value.
		send_item(access(MODE_REG_WR, OFS_CTRL + 8'd9, 8'h9F, 4'd0, 1'b0));
		send_item(access(MODE_INT_VEC, 8'h00, 8'hFF, 4'd9, 1'b0));
		send_item(access(MODE_INT_PEND, 8'h00, 8'h00, 4'd9, 1'b1));
		// Storage-only slots keep their value but drive no source.
		send_item(access(MODE_REG_WR, OFS_CTRL + 8'd10, 8'hFF, 4'd0, 1'b0));
		send_item(access(MODE_REG_RD, OFS_CTRL + 8'd10, 8'h00, 4'd0, 1'b0));
		// Indexes out of range are ignored.
		send_item(access(MODE_INT_PEND, 8'h00, 8'h00, 4'd15, 1'b1));
		send_item(access(MODE_EXT_VEC, 8'h00, 8'hFF, 4'd4, 1'b1));
		// Unmodeled offsets: a write is dropped and a read returns zero.
		send_item(access(MODE_REG_WR, OFS_NONE_TOP, 8'hFF, 4'd0, 1'b0));
		send_item(access(MODE_REG_RD, OFS_NONE_TOP, 8'h00, 4'd0, 1'b0));
		send_item(access(MODE_REG_RD, OFS_NONE_LOW, 8'h00, 4'd0, 1'b0));
		// Unused modes with every field at its maximum.
		send_item(access(MODE_SPARE_LO, 8'hFF, 8'hFF, 4'hF, 1'b1));
		send_item(access(MODE_SPARE_HI, 8'hFF, 8'hFF, 4'hF, 1'b1));
		// Remap the pins, raise irq3 at level 6, and clear source 9 and the irq7 pin; source 0 still wins at level 7.
		send_item(access(MODE_REG_WR, OFS_PIN, 8'hFF, 4'd0, 1'b0));
		send_item(access(MODE_EXT_PEND, 8'h00, 8'h00, 4'd2, 1'b1));
		send_item(access(MODE_INT_PEND, 8'h00, 8'h00, 4'd9, 1'b0));
		send_item(access(MODE_EXT_PEND, 8'h00, 8'h00, 4'd0, 1'b0));

		// The sender holds back here until every response item has come back.
		drain();

		// Random part, one phase per idling mix, drained in between.
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(random_access());
			drain();
		end

		// Give the two-stage response path time to show any stray item.
		stall_pct = 0;
		repeat (8) @(negedge clk);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop: far beyond the slowest correct run of this stimulus.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
